// ===== hdl/kmp_prefix_border_counter_defines.svh =====
// ----------------------------------------------------------------------------
// KMP prefix border counter: assertion macros
// Shared concurrent assertion helpers for the matcher RTL.
// ----------------------------------------------------------------------------
`ifndef KMP_PREFIX_BORDER_COUNTER_DEFINES_SVH
`define KMP_PREFIX_BORDER_COUNTER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define KPBC_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define KPBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/kpbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KMP prefix border counter package
// Shared constants, operation codes and the result record.
// ----------------------------------------------------------------------------
package kpbc_pkg;

  // Default pattern capacity in characters.
  localparam int PAT_MAX_DEF = 1024;

  // Width of the count and length fields of a result.
  localparam int OUT_W = 11;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    logic [OUT_W-1:0] prefix_count;
    logic [OUT_W-1:0] match_len;
    logic             overflow;
  } res_t;

endpackage

// ===== hdl/kpbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KPBC simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kpbc_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/kpbc_ctrl.sv =====
`timescale 1ns / 1ps
`include "kmp_prefix_border_counter_defines.svh"
// ----------------------------------------------------------------------------
// KPBC control and table memories
// Sequencer that walks the failure links in the pattern memories.
// ----------------------------------------------------------------------------
module kpbc_ctrl import kpbc_pkg::*; #(
  parameter int PAT_MAX = PAT_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] op_i,
  input  logic [7:0] ch_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_t       res_o
);

  localparam int IW = $clog2(PAT_MAX + 1);
  localparam int CW = $clog2(PAT_MAX);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_FIX  = 3'd2;
  localparam logic [2:0] ST_BC   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [IW-1:0] CAP = IW'(PAT_MAX);

  logic [2:0]    state_q, state_d;
  logic [1:0]    op_q, op_d;
  logic [7:0]    ch_q, ch_d;
  logic [IW-1:0] k_q, k_d;
  logic [IW-1:0] len_q, len_d;
  logic [IW-1:0] bb_q, bb_d;
  logic [IW-1:0] match_q, match_d;
  res_t          res_q, res_d;

  logic          char_we, char_re;
  logic [CW-1:0] char_waddr, char_raddr;
  logic [7:0]    char_rdata;
  logic          link_we, link_re;
  logic [IW-1:0] link_waddr, link_raddr, link_rdata;
  logic          bc_we, bc_re;
  logic [IW-1:0] bc_waddr, bc_raddr, bc_wdata, bc_rdata;

  logic [IW-1:0] kn;
  logic [IW-1:0] k0;
  logic [IW-1:0] bc_val;

  function automatic logic [OUT_W-1:0] fit(input logic [IW-1:0] v);
    logic [IW+OUT_W-1:0] t;
    t = {{OUT_W{1'b0}}, v};
    return t[OUT_W-1:0];
  endfunction

  kpbc_ram #(.DEPTH(PAT_MAX), .DW(8)) u_char_ram (
    .clk_i  (clk_i),
    .we_i   (char_we),
    .waddr_i(char_waddr),
    .wdata_i(ch_q),
    .re_i   (char_re),
    .raddr_i(char_raddr),
    .rdata_o(char_rdata)
  );

  kpbc_ram #(.DEPTH(PAT_MAX + 1), .DW(IW)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(k_q),
    .re_i   (link_re),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  kpbc_ram #(.DEPTH(PAT_MAX + 1), .DW(IW)) u_bc_ram (
    .clk_i  (clk_i),
    .we_i   (bc_we),
    .waddr_i(bc_waddr),
    .wdata_i(bc_wdata),
    .re_i   (bc_re),
    .raddr_i(bc_raddr),
    .rdata_o(bc_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  // Entry zero of the border count table is always zero, so it is never stored.
  assign bc_val   = (k_q == '0) ? '0 : bc_rdata;
  assign bc_wdata = bc_val + IW'(1);
  assign k0       = (match_q >= len_q) ? '0 : match_q;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ch_d       = ch_q;
    k_d        = k_q;
    len_d      = len_q;
    bb_d       = bb_q;
    match_d    = match_q;
    res_d      = res_q;
    kn         = k_q;
    char_we    = 1'b0;
    char_waddr = len_q[CW-1:0];
    char_re    = 1'b0;
    char_raddr = k_q[CW-1:0];
    link_we    = 1'b0;
    link_waddr = len_q + IW'(1);
    link_re    = 1'b0;
    link_raddr = k_q;
    bc_we      = 1'b0;
    bc_waddr   = len_q + IW'(1);
    bc_re      = 1'b0;
    bc_raddr   = k_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          ch_d    = ch_i;
          res_d   = '0;
          state_d = ST_DONE;
          unique case (op_i)
            OP_APPEND: begin
              if (len_q == CAP) begin
                res_d.overflow = 1'b1;
              end else if (len_q == '0) begin
                k_d      = '0;
                bc_re    = 1'b1;
                bc_raddr = '0;
                state_d  = ST_BC;
              end else begin
                k_d        = bb_q;
                char_re    = 1'b1;
                char_raddr = bb_q[CW-1:0];
                link_re    = 1'b1;
                link_raddr = bb_q;
                state_d    = ST_CMP;
              end
            end
            OP_TEXT: begin
              if (len_q == '0) begin
                match_d = '0;
              end else begin
                k_d        = k0;
                char_re    = 1'b1;
                char_raddr = k0[CW-1:0];
                link_re    = 1'b1;
                link_raddr = k0;
                state_d    = ST_CMP;
              end
            end
            OP_CLEAR: begin
              len_d   = '0;
              bb_d    = '0;
              match_d = '0;
            end
            default: begin
              res_d.match_len = fit(match_q);
            end
          endcase
        end
      end

      ST_CMP: begin
        if (char_rdata == ch_q) begin
          kn = k_q + IW'(1);
        end else if (k_q == '0) begin
          kn = '0;
        end else begin
          kn = link_rdata;
        end
        k_d = kn;
        if (char_rdata != ch_q && k_q != '0) begin
          // Mismatch: follow the failure link and compare again.
          char_re    = 1'b1;
          char_raddr = kn[CW-1:0];
          link_re    = 1'b1;
          link_raddr = kn;
        end else if (op_q == OP_TEXT && kn == len_q) begin
          // A full match falls back to its border.
          link_re    = 1'b1;
          link_raddr = kn;
          state_d    = ST_FIX;
        end else begin
          bc_re    = 1'b1;
          bc_raddr = kn;
          state_d  = ST_BC;
        end
      end

      ST_FIX: begin
        k_d      = link_rdata;
        bc_re    = 1'b1;
        bc_raddr = link_rdata;
        state_d  = ST_BC;
      end

      ST_BC: begin
        state_d         = ST_DONE;
        res_d.match_len = fit(k_q);
        res_d.overflow  = 1'b0;
        if (op_q == OP_APPEND) begin
          char_we            = 1'b1;
          link_we            = 1'b1;
          bc_we              = 1'b1;
          len_d              = len_q + IW'(1);
          bb_d               = k_q;
          match_d            = '0;
          res_d.prefix_count = fit(bc_wdata);
        end else begin
          match_d            = k_q;
          res_d.prefix_count = fit(bc_val);
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      bb_q    <= '0;
      match_q <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      bb_q    <= bb_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    ch_q  <= ch_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  `KPBC_ASSERT_ALWAYS(a_len_cap, clk_i, rst_ni, len_q <= CAP, "pattern length beyond capacity")
  `KPBC_ASSERT_ALWAYS(a_match_lt_len, clk_i, rst_ni, match_q == '0 || match_q < len_q, "match length not below pattern length")
  `KPBC_ASSERT_ALWAYS(a_walk_in_pattern, clk_i, rst_ni, state_q != ST_CMP || k_q < len_q, "failure walk left the stored pattern")
  `KPBC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, state_q == ST_DONE && !res_ready_i, state_q == ST_DONE && $stable(res_q), "pending result changed")

endmodule

// ===== hdl/kmp_prefix_border_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KMP prefix border counter
// Online Knuth-Morris-Pratt matcher counting pattern prefixes at each text item.
// ----------------------------------------------------------------------------
// Every input item gives exactly one result item. A pattern or text item that
// compares characters goes through accept, character compare, border count
// read and hand-off to the output register, with one more compare step for every
// failure link followed, since each step of the walk is one read of the pattern
// and link memories, and one more step when a text item completes a full match
// and falls back to its border. The first append to an empty pattern skips the
// compare. Ops that touch no memory (clear, full-pattern append, empty-pattern
// text, the unused op code) go from accept straight to hand-off. The pattern,
// failure links and border counts live in on-chip RAMs; no clearing pass is
// needed after reset. A new item is accepted while the previous result still
// waits in the output register.
module kmp_prefix_border_counter import kpbc_pkg::*; #(
  parameter int PAT_MAX = PAT_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] ch
  input  logic [1:0]  s_axis_tuser,  // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [10:0] prefix_count, [21:11] match_len, zero pad
  output logic        m_axis_tuser   // [0] overflow
);

  logic res_valid, res_ready;
  res_t res;
  logic out_valid_q, out_valid_d;
  res_t out_q;

  kpbc_ctrl #(.PAT_MAX(PAT_MAX)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .ch_i       (s_axis_tdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.match_len, out_q.prefix_count};
  assign m_axis_tuser  = out_q.overflow;

endmodule
